// ===== design/ieval_pkg.sv =====
// ieval_pkg: operator codes, status codes, symbol decoding, precedence relation
// and controller/datapath command and status structs for the infix evaluator.
// No dependencies.
package ieval_pkg;

    typedef enum logic [2:0] {
        OP_END  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_LPAR = 3'd5,
        OP_RPAR = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIVZERO = 3'd1;
    localparam logic [2:0] ST_UNDER   = 3'd2;
    localparam logic [2:0] ST_OVER    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [8:0] CH_ZERO  = 9'h030;

    typedef enum logic [1:0] {
        REL_PUSH   = 2'd0,
        REL_MATCH  = 2'd1,
        REL_REDUCE = 2'd2
    } rel_t;

    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_NEXT = 2'd1,
        RD_BASE = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic       load_sym;
        logic       push_opnd;
        logic       push_oprt;
        logic       pop_oprt;
        rd_sel_t    rd_sel;
        logic       latch_b;
        logic       exec;
        logic       iter_step;
        logic       finish;
        logic       writeback;
        logic       res_clear;
        logic       res_load;
        logic       emit;
        logic [2:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic punct;
        op_t  code;
        logic opnd_full;
        logic opnd_empty;
        logic opnd_lt2;
        logic oprt_full;
        op_t  top;
        logic b_zero;
        logic iter_last;
        logic out_free;
    } sts_t;

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic op_t op_code(input logic [7:0] c);
        op_t r;
        unique case (c)
            CH_END:  r = OP_END;
            CH_ADD:  r = OP_ADD;
            CH_SUB:  r = OP_SUB;
            CH_MUL:  r = OP_MUL;
            CH_DIV:  r = OP_DIV;
            CH_LPAR: r = OP_LPAR;
            CH_RPAR: r = OP_RPAR;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_arith(input op_t op);
        return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    endfunction

    function automatic rel_t precede(input op_t top, input op_t in);
        rel_t r;
        unique case (in)
            OP_ADD, OP_SUB: r = is_arith(top) ? REL_REDUCE : REL_PUSH;
            OP_MUL, OP_DIV: r = (top == OP_MUL || top == OP_DIV) ? REL_REDUCE : REL_PUSH;
            OP_LPAR:        r = REL_PUSH;
            OP_RPAR:        r = (top == OP_LPAR) ? REL_MATCH : REL_REDUCE;
            default:        r = (top == OP_END) ? REL_MATCH : REL_REDUCE;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ieval_ctrl.sv =====
// ieval_ctrl: sequencing state machine for the infix evaluator.
// Depends on ieval_pkg; drives ieval_dpath through cmd_t, observes sts_t.
module ieval_ctrl
    import ieval_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic symbol_valid,
    output logic symbol_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_TOPRD  = 11'b00000000100,
        S_EVAL   = 11'b00000001000,
        S_RDA    = 11'b00000010000,
        S_EXEC   = 11'b00000100000,
        S_ITER   = 11'b00001000000,
        S_FIN    = 11'b00010000000,
        S_WB     = 11'b00100000000,
        S_BASE   = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] st_reg, st_next;

    assign symbol_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        st_next         = st_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_TOP;
        cmd.emit_status = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (symbol_valid)
                begin
                    cmd.load_sym = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.punct)
                begin
                    if (sts.opnd_full)
                    begin
                        st_next       = ST_OVER;
                        cmd.res_clear = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        cmd.push_opnd = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (sts.code == OP_NONE)
                begin
                    st_next       = ST_UNKNOWN;
                    cmd.res_clear = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_TOPRD;
                end
            end
            S_TOPRD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.code == OP_END && sts.top == OP_END)
                begin
                    if (sts.opnd_empty)
                    begin
                        st_next       = ST_UNDER;
                        cmd.res_clear = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_BASE;
                        state_next = S_BASE;
                    end
                end
                else
                begin
                    unique case (precede(sts.top, sts.code))
                        REL_PUSH:
                        begin
                            if (sts.oprt_full)
                            begin
                                st_next       = ST_OVER;
                                cmd.res_clear = 1'b1;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                cmd.push_oprt = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        REL_MATCH:
                        begin
                            cmd.pop_oprt = 1'b1;
                            state_next   = S_IDLE;
                        end
                        default:
                        begin
                            if (!is_arith(sts.top) || sts.opnd_lt2)
                            begin
                                st_next       = ST_UNDER;
                                cmd.res_clear = 1'b1;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_TOP;
                                state_next = S_RDA;
                            end
                        end
                    endcase
                end
            end
            S_RDA:
            begin
                cmd.latch_b = 1'b1;
                cmd.rd_sel  = RD_NEXT;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.top == OP_DIV && sts.b_zero)
                begin
                    st_next       = ST_DIVZERO;
                    cmd.res_clear = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = (sts.top == OP_MUL || sts.top == OP_DIV) ? S_ITER : S_WB;
                end
            end
            S_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (sts.iter_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = S_TOPRD;
            end
            S_BASE:
            begin
                cmd.res_load = 1'b1;
                st_next      = ST_OK;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ieval_dpath.sv =====
// ieval_dpath: operand and operator stacks, shift-add multiplier, restoring
// divider and output register. Depends on ieval_pkg; commanded by ieval_ctrl.
module ieval_dpath
    import ieval_pkg::*;
#(
    parameter int OPERAND_DEPTH  = 64,
    parameter int OPERATOR_DEPTH = 64,
    parameter int VALUE_WIDTH    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         symbol,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    input  cmd_t               cmd,
    output sts_t               sts
);

    localparam int VW  = VALUE_WIDTH;
    localparam int OCW = $clog2(OPERAND_DEPTH + 1);
    localparam int OIW = $clog2(OPERAND_DEPTH);
    localparam int PCW = $clog2(OPERATOR_DEPTH + 1);
    localparam int PIW = $clog2(OPERATOR_DEPTH);
    localparam int CW  = $clog2(VW + 1);

    logic [VW-1:0] opnd_mem [OPERAND_DEPTH];
    logic [2:0]    oprt_mem [OPERATOR_DEPTH];

    logic [7:0]     sym_reg;
    logic [OCW-1:0] opnd_cnt_reg, opnd_cnt_next;
    logic [PCW-1:0] oprt_cnt_reg, oprt_cnt_next;
    logic [VW-1:0]  rd_q_reg;
    logic [2:0]     oprt_q_reg;
    logic [VW-1:0]  b_reg;
    logic [VW-1:0]  res_reg;
    logic [VW-1:0]  acc_reg;
    logic [VW-1:0]  x_reg;
    logic [VW-1:0]  y_reg;
    logic           neg_reg;
    logic [CW-1:0]  it_reg;
    logic           out_valid_reg;
    logic [31:0]    out_value_reg;
    logic [2:0]     out_status_reg;

    logic signed [8:0] digit;
    logic [OCW-1:0]    rd_addr;
    logic [VW-1:0]     a_mag, b_mag;
    logic [VW:0]       trial;
    logic              is_div;
    logic signed [VW-1:0] res_s;

    assign digit = $signed({1'b0, sym_reg}) - $signed(CH_ZERO);
    assign is_div = (sts.top == OP_DIV);
    assign a_mag = rd_q_reg[VW-1] ? (~rd_q_reg + 1'b1) : rd_q_reg;
    assign b_mag = b_reg[VW-1] ? (~b_reg + 1'b1) : b_reg;
    assign trial = {acc_reg, x_reg[VW-1]} - {1'b0, y_reg};
    assign res_s = $signed(res_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT: rd_addr = opnd_cnt_reg - OCW'(2);
            RD_BASE: rd_addr = '0;
            default: rd_addr = opnd_cnt_reg - OCW'(1);
        endcase
    end

    assign sts.punct      = is_punct(sym_reg);
    assign sts.code       = op_code(sym_reg);
    assign sts.opnd_full  = (opnd_cnt_reg >= OCW'(OPERAND_DEPTH));
    assign sts.opnd_empty = (opnd_cnt_reg == '0);
    assign sts.opnd_lt2   = (opnd_cnt_reg < OCW'(2));
    assign sts.oprt_full  = (oprt_cnt_reg >= PCW'(OPERATOR_DEPTH));
    assign sts.top        = (oprt_cnt_reg == PCW'(1)) ? OP_END : op_t'(oprt_q_reg);
    assign sts.b_zero     = (b_reg == '0);
    assign sts.iter_last  = (it_reg == CW'(1));
    assign sts.out_free   = !out_valid_reg || !result_stall;

    // stacks
    always_ff @(posedge clk)
    begin
        rd_q_reg   <= opnd_mem[rd_addr[OIW-1:0]];
        oprt_q_reg <= oprt_mem[PIW'(oprt_cnt_reg - PCW'(1))];
        if (cmd.push_opnd)
        begin
            opnd_mem[opnd_cnt_reg[OIW-1:0]] <= VW'(digit);
        end
        else if (cmd.writeback)
        begin
            opnd_mem[OIW'(opnd_cnt_reg - OCW'(2))] <= res_reg;
        end
        if (cmd.push_oprt)
        begin
            oprt_mem[oprt_cnt_reg[PIW-1:0]] <= sts.code;
        end
    end

    always_comb
    begin
        opnd_cnt_next = opnd_cnt_reg;
        oprt_cnt_next = oprt_cnt_reg;
        if (cmd.emit)
        begin
            opnd_cnt_next = '0;
            oprt_cnt_next = PCW'(1);
        end
        else
        begin
            if (cmd.push_opnd)
            begin
                opnd_cnt_next = opnd_cnt_reg + OCW'(1);
            end
            if (cmd.writeback)
            begin
                opnd_cnt_next = opnd_cnt_reg - OCW'(1);
            end
            if (cmd.push_oprt)
            begin
                oprt_cnt_next = oprt_cnt_reg + PCW'(1);
            end
            if (cmd.pop_oprt || cmd.writeback)
            begin
                oprt_cnt_next = oprt_cnt_reg - PCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_cnt_reg  <= '0;
            oprt_cnt_reg  <= PCW'(1);
            out_valid_reg <= 1'b0;
            it_reg        <= '0;
        end
        else
        begin
            opnd_cnt_reg <= opnd_cnt_next;
            oprt_cnt_reg <= oprt_cnt_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                it_reg <= CW'(VW);
            end
            else if (cmd.iter_step)
            begin
                it_reg <= it_reg - CW'(1);
            end
        end
    end

    // arithmetic: x/y hold multiplicand/multiplier or dividend/divisor, acc the
    // partial product or partial remainder
    always_ff @(posedge clk)
    begin
        if (cmd.load_sym)
        begin
            sym_reg <= symbol;
        end
        if (cmd.latch_b)
        begin
            b_reg <= rd_q_reg;
        end
        if (cmd.exec)
        begin
            acc_reg <= '0;
            neg_reg <= rd_q_reg[VW-1] ^ b_reg[VW-1];
            x_reg   <= is_div ? a_mag : rd_q_reg;
            y_reg   <= is_div ? b_mag : b_reg;
            if (sts.top == OP_SUB)
            begin
                res_reg <= rd_q_reg - b_reg;
            end
            else
            begin
                res_reg <= rd_q_reg + b_reg;
            end
        end
        else if (cmd.iter_step)
        begin
            if (is_div)
            begin
                if (!trial[VW])
                begin
                    acc_reg <= trial[VW-1:0];
                    x_reg   <= {x_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= {acc_reg[VW-2:0], x_reg[VW-1]};
                    x_reg   <= {x_reg[VW-2:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[VW-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[VW-1:1]};
            end
        end
        else if (cmd.finish)
        begin
            if (is_div)
            begin
                res_reg <= neg_reg ? (~x_reg + 1'b1) : x_reg;
            end
            else
            begin
                res_reg <= acc_reg;
            end
        end
        else if (cmd.res_clear)
        begin
            res_reg <= '0;
        end
        else if (cmd.res_load)
        begin
            res_reg <= rd_q_reg;
        end
        if (cmd.emit)
        begin
            out_value_reg  <= 32'(res_s);
            out_status_reg <= cmd.emit_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = $signed(out_value_reg);
    assign status       = out_status_reg;

endmodule

// ===== design/infix_expression_evaluator_top.sv =====
// Infix expression evaluator, two-stack operator precedence scheme.
// Channels: symbol_valid/symbol_stall carry one character per transaction;
// result_valid/result_stall carry value and status of a finished expression
// or of an error.
// Sequencing: a digit is loaded and pushed; an operator is loaded, decoded and
// compared with the stack top; each reduction it triggers reads both operands,
// executes and writes back, with * and / stepping through the one-bit-per-cycle
// shift-add multiplier/restoring divider unit. Stack accesses go through one
// registered read port per stack. The end marker loads the bottom operand as result.
// Throughput: one character at a time; symbol_stall is high while it is
// worked on. The result sits in an output register, so the next character is
// taken while a result still waits.
// Reset empties both stacks (the operator stack holds only its bottom marker)
// and clears result_valid. Every result, error or not, also empties the stacks.
// If a result is stalled and another one is ready, the block holds it back and
// keeps symbol_stall high until the output register frees up.
module infix_expression_evaluator_top
    import ieval_pkg::*;
#(
    parameter int OPERAND_DEPTH  = 64,
    parameter int OPERATOR_DEPTH = 64,
    parameter int VALUE_WIDTH    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               symbol_valid,
    output logic               symbol_stall,
    input  logic [7:0]         symbol,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] value,
    output logic [2:0]         status
);

    cmd_t cmd;
    sts_t sts;

    ieval_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    ieval_dpath #(
        .OPERAND_DEPTH  (OPERAND_DEPTH),
        .OPERATOR_DEPTH (OPERATOR_DEPTH),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (symbol),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .status       (status),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ===== design/ieval_checker.sv =====
// ieval_checker: port-level assertions for the infix evaluator, bound to
// infix_expression_evaluator_top. Depends on ieval_pkg.
module ieval_checker
    import ieval_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               symbol_valid,
    input logic               symbol_stall,
    input logic [7:0]         symbol,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] value,
    input logic [2:0]         status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(value) && $stable(status))
        else $error("stalled result transaction changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> value == 32'sd0)
        else $error("error result with non-zero value");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= ST_UNKNOWN)
        else $error("status code out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_stall |=> symbol_stall)
        else $error("input taken again without decode cycle");

endmodule

bind infix_expression_evaluator_top ieval_checker u_ieval_checker (.*);
